// ----- design/pba_pkg.sv -----
package pba_pkg;

  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_LOG2   = $clog2(PAGE_BYTES);
  localparam int ALIGN_BYTES = 16;
  localparam int FRAMES_DEF  = 16;

  localparam int REQ_W    = 16;
  localparam int ADDR_W   = 16;
  localparam int RES_W    = 17;
  localparam int STATUS_W = 3;
  localparam int OFF_W    = $clog2(PAGE_BYTES + 1);
  localparam int LIVE_W   = 16;
  localparam int AFRM_W   = ADDR_W - PAGE_LOG2;

  localparam logic [LIVE_W-1:0] LIVE_MAX = '1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_TOO_LARGE   = 3'd1,
    ST_EXHAUSTED   = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_DOUBLE_FREE = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TOO_LARGE,
    OP_TAIL_LIST,
    OP_TAIL_META,
    OP_SCAN_START,
    OP_SCAN_NEXT,
    OP_GRANT,
    OP_NEW,
    OP_EXHAUST,
    OP_NOT_FOUND,
    OP_FREE_RD,
    OP_DOUBLE,
    OP_FREE_DEC,
    OP_RELEASE,
    OP_FIND_NEXT,
    OP_FIND_HIT,
    OP_SHIFT,
    OP_SHIFT_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   take_in;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_large;
    logic no_pages;
    logic addr_bad;
    logic tail_fit;
    logic scan_fit;
    logic more;
    logic free_avail;
    logic live_zero;
    logic rel_page;
    logic found;
  } dp_stat_t;

endpackage

// ----- design/pba_req_if.sv -----
interface pba_req_if import pba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [REQ_W-1:0]  req_size;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output kind, output req_size, output address, input ready);
  modport sink (input valid, input kind, input req_size, input address, output ready);
endinterface

// ----- design/pba_rsp_if.sv -----
interface pba_rsp_if import pba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [RES_W-1:0]    alloc_address;
  logic [RES_W-1:0]    aligned_size;

  modport source (output valid, output status, output alloc_address, output aligned_size,
                  input ready);
  modport sink (input valid, input status, input alloc_address, input aligned_size,
                output ready);
endinterface

// ----- design/pba_ram.sv -----
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/pba_dp.sv -----
module pba_dp import pba_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                kind,
  input  logic [REQ_W-1:0]    req_size,
  input  logic [ADDR_W-1:0]   address,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic [STATUS_W-1:0] status,
  output logic [RES_W-1:0]    alloc_address,
  output logic [RES_W-1:0]    aligned_size
);

  localparam int FW     = $clog2(FRAMES);
  localparam int CW     = $clog2(FRAMES + 1);
  localparam int IW     = CW + 1;
  localparam int META_W = OFF_W + LIVE_W;
  localparam int SW     = RES_W + 1;
  localparam logic [RES_W-1:0] ALIGN_MASK = RES_W'(ALIGN_BYTES - 1);

  logic              kind_r;
  logic [RES_W-1:0]  size_r;
  logic [AFRM_W-1:0] afrm_r;
  logic [FRAMES-1:0] listed;
  logic [CW-1:0]     count;
  logic [FW-1:0]     idx;
  logic [FW-1:0]     cur_frame;
  status_t           res_status;
  logic [RES_W-1:0]  res_addr;
  logic [RES_W-1:0]  res_size;

  logic [RES_W-1:0]  size_in;
  logic [FW-1:0]     frm;
  logic              in_pool;
  logic [IW-1:0]     idx1;
  logic [IW-1:0]     idx2;
  logic              more;
  logic              more2;
  logic [OFF_W-1:0]  meta_off;
  logic [LIVE_W-1:0] meta_live;
  logic [SW-1:0]     fit_sum;
  logic [LIVE_W-1:0] live_inc;
  logic [FW-1:0]     ff;
  logic              free_avail;

  logic              list_we;
  logic [FW-1:0]     list_waddr;
  logic [FW-1:0]     list_wdata;
  logic              list_re;
  logic [FW-1:0]     list_raddr;
  logic [FW-1:0]     list_rdata;
  logic              meta_we;
  logic [FW-1:0]     meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic              meta_re;
  logic [FW-1:0]     meta_raddr;
  logic [META_W-1:0] meta_rdata;

  assign size_in   = (RES_W'(req_size) + ALIGN_MASK) & ~ALIGN_MASK;
  assign frm       = FW'(afrm_r);
  assign in_pool   = 32'(afrm_r) < 32'(FRAMES);
  assign idx1      = IW'(idx) + IW'(1);
  assign idx2      = IW'(idx) + IW'(2);
  assign more      = idx1 < IW'(count);
  assign more2     = idx2 < IW'(count);
  assign meta_off  = meta_rdata[META_W-1:LIVE_W];
  assign meta_live = meta_rdata[LIVE_W-1:0];
  assign fit_sum   = SW'(meta_off) + SW'(size_r);
  assign live_inc  = (meta_live == LIVE_MAX) ? meta_live : meta_live + LIVE_W'(1);

  always_comb begin
    free_avail = 1'b0;
    ff         = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!listed[i]) begin
        free_avail = 1'b1;
        ff         = FW'(i);
      end
    end
  end

  assign stat.is_free    = (kind_r == KIND_FREE);
  assign stat.too_large  = size_r > RES_W'(PAGE_BYTES);
  assign stat.no_pages   = (count == '0);
  assign stat.addr_bad   = !in_pool || !listed[frm];
  assign stat.tail_fit   = fit_sum < SW'(PAGE_BYTES);
  assign stat.scan_fit   = fit_sum <= SW'(PAGE_BYTES);
  assign stat.more       = more;
  assign stat.free_avail = free_avail;
  assign stat.live_zero  = (meta_live == '0);
  assign stat.rel_page   = (meta_live == LIVE_W'(1)) && (count >= CW'(2));
  assign stat.found      = (list_rdata == frm);

  always_comb begin
    list_we    = 1'b0;
    list_waddr = idx;
    list_wdata = list_rdata;
    list_re    = 1'b0;
    list_raddr = '0;
    meta_we    = 1'b0;
    meta_waddr = frm;
    meta_wdata = '0;
    meta_re    = 1'b0;
    meta_raddr = list_rdata;
    unique case (cmd.op)
      OP_TAIL_LIST: begin
        list_re    = 1'b1;
        list_raddr = FW'(count - CW'(1));
      end
      OP_TAIL_META: begin
        meta_re = 1'b1;
        list_re = 1'b1;
      end
      OP_SCAN_START: begin
        meta_re    = 1'b1;
        list_re    = more;
        list_raddr = FW'(idx1);
      end
      OP_SCAN_NEXT: begin
        meta_re    = 1'b1;
        list_re    = more2;
        list_raddr = FW'(idx2);
      end
      OP_GRANT: begin
        meta_we    = 1'b1;
        meta_waddr = cur_frame;
        meta_wdata = {OFF_W'(fit_sum), live_inc};
      end
      OP_NEW: begin
        list_we    = 1'b1;
        list_waddr = FW'(count);
        list_wdata = ff;
        meta_we    = 1'b1;
        meta_waddr = ff;
        meta_wdata = {OFF_W'(size_r), LIVE_W'(1)};
      end
      OP_FREE_RD: begin
        meta_re    = 1'b1;
        meta_raddr = frm;
      end
      OP_FREE_DEC: begin
        meta_we    = 1'b1;
        meta_wdata = {meta_off, meta_live - LIVE_W'(1)};
      end
      OP_RELEASE: begin
        meta_we = 1'b1;
        list_re = 1'b1;
      end
      OP_FIND_NEXT, OP_FIND_HIT: begin
        list_re    = more;
        list_raddr = FW'(idx1);
      end
      OP_SHIFT: begin
        list_we    = 1'b1;
        list_re    = more2;
        list_raddr = FW'(idx2);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      listed <= '0;
      count  <= '0;
    end else begin
      unique case (cmd.op)
        OP_NEW: begin
          listed[ff] <= 1'b1;
          count      <= count + CW'(1);
        end
        OP_SHIFT_END: begin
          listed[frm] <= 1'b0;
          count       <= count - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      kind_r <= kind;
      size_r <= size_in;
      afrm_r <= address[ADDR_W-1:PAGE_LOG2];
      idx    <= '0;
    end
    unique case (cmd.op)
      OP_TOO_LARGE: begin
        res_status <= ST_TOO_LARGE;
        res_addr   <= '0;
        res_size   <= size_r;
      end
      OP_TAIL_META, OP_SCAN_START: cur_frame <= list_rdata;
      OP_SCAN_NEXT: begin
        cur_frame <= list_rdata;
        idx       <= FW'(idx1);
      end
      OP_GRANT: begin
        res_status <= ST_OK;
        res_addr   <= RES_W'((32'(cur_frame) << PAGE_LOG2) + 32'(meta_off));
        res_size   <= size_r;
      end
      OP_NEW: begin
        res_status <= ST_OK;
        res_addr   <= RES_W'(32'(ff) << PAGE_LOG2);
        res_size   <= size_r;
      end
      OP_EXHAUST: begin
        res_status <= ST_EXHAUSTED;
        res_addr   <= '0;
        res_size   <= size_r;
      end
      OP_NOT_FOUND: begin
        res_status <= ST_NOT_FOUND;
        res_addr   <= '0;
        res_size   <= '0;
      end
      OP_DOUBLE: begin
        res_status <= ST_DOUBLE_FREE;
        res_addr   <= '0;
        res_size   <= '0;
      end
      OP_FREE_DEC, OP_RELEASE: begin
        res_status <= ST_OK;
        res_addr   <= '0;
        res_size   <= '0;
      end
      OP_FIND_NEXT, OP_SHIFT: idx <= FW'(idx1);
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      status        <= res_status;
      alloc_address <= res_addr;
      aligned_size  <= res_size;
    end
  end

  pba_ram #(.WIDTH(FW), .DEPTH(FRAMES)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .re    (list_re),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  pba_ram #(.WIDTH(META_W), .DEPTH(FRAMES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FRAMES))
    else $error("listed count above frame pool size");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(listed) == 32'(count))
    else $error("listed count out of step with listed frames");

endmodule

// ----- design/pba_ctrl.sv -----
module pba_ctrl import pba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_DECODE    = 10'b00_0000_0010,
    S_TAIL_META = 10'b00_0000_0100,
    S_TAIL_CHK  = 10'b00_0000_1000,
    S_SCAN      = 10'b00_0001_0000,
    S_NEW       = 10'b00_0010_0000,
    S_FREE_META = 10'b00_0100_0000,
    S_FIND      = 10'b00_1000_0000,
    S_SHIFT     = 10'b01_0000_0000,
    S_OUT       = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.take_in  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.is_free) begin
          if (stat.addr_bad) begin
            cmd.op     = OP_NOT_FOUND;
            state_next = S_OUT;
          end else begin
            cmd.op     = OP_FREE_RD;
            state_next = S_FREE_META;
          end
        end else if (stat.too_large) begin
          cmd.op     = OP_TOO_LARGE;
          state_next = S_OUT;
        end else if (stat.no_pages) begin
          state_next = S_NEW;
        end else begin
          cmd.op     = OP_TAIL_LIST;
          state_next = S_TAIL_META;
        end
      end
      S_TAIL_META: begin
        cmd.op     = OP_TAIL_META;
        state_next = S_TAIL_CHK;
      end
      S_TAIL_CHK: begin
        if (stat.tail_fit) begin
          cmd.op     = OP_GRANT;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_SCAN_START;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat.scan_fit) begin
          cmd.op     = OP_GRANT;
          state_next = S_OUT;
        end else if (stat.more) begin
          cmd.op = OP_SCAN_NEXT;
        end else begin
          state_next = S_NEW;
        end
      end
      S_NEW: begin
        cmd.op     = stat.free_avail ? OP_NEW : OP_EXHAUST;
        state_next = S_OUT;
      end
      S_FREE_META: begin
        priority if (stat.live_zero) begin
          cmd.op     = OP_DOUBLE;
          state_next = S_OUT;
        end else if (stat.rel_page) begin
          cmd.op     = OP_RELEASE;
          state_next = S_FIND;
        end else begin
          cmd.op     = OP_FREE_DEC;
          state_next = S_OUT;
        end
      end
      S_FIND: begin
        priority if (stat.found) begin
          cmd.op     = OP_FIND_HIT;
          state_next = S_SHIFT;
        end else if (stat.more) begin
          cmd.op = OP_FIND_NEXT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SHIFT: begin
        if (stat.more) begin
          cmd.op = OP_SHIFT;
        end else begin
          cmd.op     = OP_SHIFT_END;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.load_out | (out_valid & ~out_ready);
    end
  end

  a_take_decodes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECODE))
    else $error("accepted transaction not decoded");

  a_load_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while occupied");

  a_rise_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result presented outside the output state");

endmodule

// ----- design/page_bump_allocator.sv -----
// Channel  Role   Payload                              Notes
// req      sink   kind, req_size, address              allocate (kind 0) or free (kind 1)
// rsp      source status, alloc_address, aligned_size  one transaction per request
//
// One request at a time; req.ready is high only when idle.
// Allocate: too large ends at once; an empty list takes a new frame; else the tail page is
// tried, then the list is scanned from its head, then a new frame is taken or none is left.
// Free: not found, double free or decrement; a last block releases its page if more are listed.
// A held result lets the next request run up to its output state, which then waits on rsp.
// rst is synchronous; it empties the page list, no clearing pass.
module page_bump_allocator import pba_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input logic       clk,
  input logic       rst,
  pba_req_if.sink   req,
  pba_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pba_dp #(.FRAMES(FRAMES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .kind          (req.kind),
    .req_size      (req.req_size),
    .address       (req.address),
    .cmd           (cmd),
    .stat          (stat),
    .status        (rsp.status),
    .alloc_address (rsp.alloc_address),
    .aligned_size  (rsp.aligned_size)
  );

endmodule
